// File: hw/rtl/cram_pkg.sv
// Shared widths for the 3x3 Cramer's rule solver.
`timescale 1ns / 1ps
package cram_pkg;
  localparam int unsigned InWidth  = 16;
  localparam int unsigned OutWidth = 32;
endpackage

// File: hw/rtl/cramer_3x3_solver.sv
// Top level of the pipelined 3x3 Cramer's rule solver.
`timescale 1ns / 1ps
// Pipeline: 3 determinant stages plus OUT_WIDTH + 3 divider stages.
// Throughput: one beat per cycle; the whole pipeline advances unless the
// output beat is stalled, so the depth of the divider sets the latency only.
// Reset clears the valid bits; data registers are not reset.
module cramer_3x3_solver #(
  parameter int unsigned IN_WIDTH  = cram_pkg::InWidth,
  parameter int unsigned OUT_WIDTH = cram_pkg::OutWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic signed [IN_WIDTH-1:0]  col1_x_i, col1_y_i, col1_z_i,
  input  logic signed [IN_WIDTH-1:0]  col2_x_i, col2_y_i, col2_z_i,
  input  logic signed [IN_WIDTH-1:0]  col3_x_i, col3_y_i, col3_z_i,
  input  logic signed [IN_WIDTH-1:0]  rhs_x_i, rhs_y_i, rhs_z_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [OUT_WIDTH-1:0] coef_a_o,
  output logic signed [OUT_WIDTH-1:0] coef_b_o,
  output logic signed [OUT_WIDTH-1:0] coef_c_o,
  output logic                        singular_o
);
  localparam int unsigned DW    = 3 * IN_WIDTH + 3;
  localparam int unsigned DetLat = 3;
  localparam int unsigned DivLat = OUT_WIDTH + 3;
  localparam int unsigned Depth = DetLat + DivLat;

  // The whole pipeline moves together; a stalled output freezes every stage.
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[Depth-1];

  logic signed [IN_WIDTH-1:0] c1 [3], c2 [3], c3 [3], r [3];
  assign c1 = '{col1_x_i, col1_y_i, col1_z_i};
  assign c2 = '{col2_x_i, col2_y_i, col2_z_i};
  assign c3 = '{col3_x_i, col3_y_i, col3_z_i};
  assign r  = '{rhs_x_i, rhs_y_i, rhs_z_i};

  logic signed [IN_WIDTH-1:0] mat [4][9];
  assign mat[0] = '{c1[0], c1[1], c1[2], c2[0], c2[1], c2[2], c3[0], c3[1], c3[2]};
  assign mat[1] = '{r[0], r[1], r[2], c2[0], c2[1], c2[2], c3[0], c3[1], c3[2]};
  assign mat[2] = '{c1[0], c1[1], c1[2], r[0], r[1], r[2], c3[0], c3[1], c3[2]};
  assign mat[3] = '{c1[0], c1[1], c1[2], c2[0], c2[1], c2[2], r[0], r[1], r[2]};

  logic signed [DW-1:0] det [4];
  for (genvar g = 0; g < 4; g++) begin : g_det
    cram_det #(.InWidth(IN_WIDTH), .DetWidth(DW)) u_det (
      .clk_i, .en_i(en), .m_i(mat[g]), .det_o(det[g])
    );
  end

  // A zero main determinant is held as a flag; the divider sees one instead.
  logic signed [DW-1:0] den;
  logic                 sing_q [DivLat];
  assign den = (det[0] == '0) ? DW'(1) : det[0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= det[0] == '0;
      for (int s = 1; s < DivLat; s++) sing_q[s] <= sing_q[s-1];
    end
  end

  logic signed [OUT_WIDTH-1:0] quo [3];
  for (genvar g = 0; g < 3; g++) begin : g_div
    cram_div #(.DetWidth(DW), .OutWidth(OUT_WIDTH)) u_div (
      .clk_i, .en_i(en), .num_i(det[g+1]), .den_i(den), .quo_o(quo[g])
    );
  end

  assign singular_o = sing_q[DivLat-1];
  assign coef_a_o   = singular_o ? '0 : quo[0];
  assign coef_b_o   = singular_o ? '0 : quo[1];
  assign coef_c_o   = singular_o ? '0 : quo[2];

  // A stalled output beat must not move on.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("output beat lost under stall");
  // Input stall is only raised by a stalled output.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i) else $error("spurious input stall");
  // A singular result carries zero coefficients.
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && singular_o |-> coef_a_o == '0 && coef_b_o == '0 && coef_c_o == '0)
    else $error("singular result with nonzero coefficient");
endmodule

// File: hw/rtl/cram_det.sv
// Pipelined exact 3x3 determinant: cofactor and term multiply registers, then a sum register.
`timescale 1ns / 1ps
module cram_det #(
  parameter int unsigned InWidth = cram_pkg::InWidth,
  parameter int unsigned DetWidth = 3 * InWidth + 3
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [InWidth-1:0]  m_i [9],
  output logic signed [DetWidth-1:0] det_o
);
  localparam int unsigned PW = 2 * InWidth + 1;
  localparam int unsigned TW = 3 * InWidth + 1;

  logic signed [PW-1:0]      cof_q [3];
  logic signed [InWidth-1:0] top_q [3];
  logic signed [TW-1:0]      trm_q [3];

  // m_i holds columns: m_i[3*col + row].
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cof_q[0] <= PW'(m_i[4]) * PW'(m_i[8]) - PW'(m_i[7]) * PW'(m_i[5]);
      cof_q[1] <= PW'(m_i[7]) * PW'(m_i[2]) - PW'(m_i[1]) * PW'(m_i[8]);
      cof_q[2] <= PW'(m_i[1]) * PW'(m_i[5]) - PW'(m_i[4]) * PW'(m_i[2]);
      top_q[0] <= m_i[0];
      top_q[1] <= m_i[3];
      top_q[2] <= m_i[6];
      for (int k = 0; k < 3; k++) begin
        trm_q[k] <= TW'(top_q[k]) * TW'(cof_q[k]);
      end
      det_o <= DetWidth'(trm_q[0]) + DetWidth'(trm_q[1]) + DetWidth'(trm_q[2]);
    end
  end
endmodule

// File: hw/rtl/cram_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps
module cram_div #(
  parameter int unsigned DetWidth = 51,
  parameter int unsigned OutWidth = cram_pkg::OutWidth
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [DetWidth-1:0] num_i,
  input  logic signed [DetWidth-1:0] den_i,
  output logic signed [OutWidth-1:0] quo_o
);
  localparam int unsigned Frac = OutWidth / 2;
  // Quotient bits needed to detect overflow of an OutWidth result.
  localparam int unsigned QW = OutWidth + 1;
  localparam int unsigned NW = DetWidth + Frac;
  localparam int unsigned RW = DetWidth + 1;

  logic [NW-1:0]       num_q [QW+1];
  logic [RW-1:0]       rem_q [QW+1];
  logic [DetWidth-1:0] den_q [QW+1];
  logic [QW-1:0]       quo_q [QW+1];
  logic                neg_q [QW+1];
  logic                ovf_q [QW+1];

  logic [DetWidth-1:0] nmag, dmag;
  assign nmag = num_i[DetWidth-1] ? DetWidth'(-num_i) : DetWidth'(num_i);
  assign dmag = den_i[DetWidth-1] ? DetWidth'(-den_i) : DetWidth'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // High bits above QW must be zero: check num >> QW < den up front.
      num_q[0] <= {nmag, Frac'(0)};
      den_q[0] <= dmag;
      neg_q[0] <= num_i[DetWidth-1] ^ den_i[DetWidth-1];
      ovf_q[0] <= (NW'({nmag, Frac'(0)}) >> QW) >= NW'(dmag);
      rem_q[0] <= RW'(({nmag, Frac'(0)}) >> QW);
      quo_q[0] <= '0;
      for (int s = 0; s < QW; s++) begin
        logic [RW-1:0] t;
        t = {rem_q[s][RW-2:0], num_q[s][QW-1-s]};
        if (t >= RW'(den_q[s])) begin
          rem_q[s+1] <= t - RW'(den_q[s]);
          quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= t;
          quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b0};
        end
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
      if (neg_q[QW]) begin
        if (ovf_q[QW] || quo_q[QW] >= (QW'(1) << (OutWidth - 1))) begin
          quo_o <= {1'b1, (OutWidth-1)'(0)};
        end else begin
          quo_o <= OutWidth'(-quo_q[QW]);
        end
      end else begin
        if (ovf_q[QW] || quo_q[QW] >= (QW'(1) << (OutWidth - 1))) begin
          quo_o <= {1'b0, {(OutWidth-1){1'b1}}};
        end else begin
          quo_o <= OutWidth'(quo_q[QW]);
        end
      end
    end
  end
endmodule
